// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/core/rtnh_pkg.sv -----
`default_nettype none
package rtnh_pkg;
	localparam int ACC_W = 67;
	localparam int DIV_W = 50;
	localparam int FRAC_W = 17;
	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
	localparam int NUM_REGS = 6;

	typedef logic [2:0][31:0] vec3_t;

	typedef struct packed {
		logic [31:0] corner_a_x;
		logic [31:0] corner_a_y;
		logic [31:0] corner_a_z;
		logic [31:0] corner_b_x;
		logic [31:0] corner_b_y;
		logic [31:0] corner_b_z;
		logic [31:0] corner_c_x;
		logic [31:0] corner_c_y;
		logic [31:0] corner_c_z;
		logic [7:0]  surface_tag;
		logic        final_triangle;
	} tri_req_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  hit_tag;
		logic [16:0] hit_fraction;
		logic [31:0] hit_x;
		logic [31:0] hit_y;
		logic [31:0] hit_z;
		logic [31:0] face_nx;
		logic [31:0] face_ny;
		logic [31:0] face_nz;
	} hit_req_t;

	// queued triangle: vertices plus the edge vectors ab and ac worked out on entry
	typedef struct packed {
		vec3_t      a;
		vec3_t      b;
		vec3_t      c;
		vec3_t      ab;
		vec3_t      ac;
		logic [7:0] tag;
		logic       last;
	} tri_ent_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_CROSS, ST_DOT, ST_DIV, ST_PT, ST_DIFF, ST_UPD, ST_FIN
	} st_t;

	typedef enum logic [1:0] {CS_N, CS_AB, CS_BC, CS_CA} cross_sel_t;
	typedef enum logic [1:0] {DS_DEN, DS_NUM, DS_INS} dot_sel_t;

	localparam logic [2:0] REG_SX = 3'd0;
	localparam logic [2:0] REG_SY = 3'd1;
	localparam logic [2:0] REG_SZ = 3'd2;
	localparam logic [2:0] REG_EX = 3'd3;
	localparam logic [2:0] REG_EY = 3'd4;
	localparam logic [2:0] REG_EZ = 3'd5;

	function automatic logic [31:0] sub_sat(input logic [31:0] x, input logic [31:0] y);
		logic [32:0] d;
		d = {x[31], x} - {y[31], y};
		if (d[32] != d[31])
			return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return d[31:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [ACC_W-1:0] v);
		if (&v[ACC_W-1:31] || ~|v[ACC_W-1:31])
			return v[31:0];
		return v[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	function automatic logic [1:0] nxt3(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

	function automatic vec3_t vsub(input vec3_t x, input vec3_t y);
		vec3_t r;
		for (int i = 0; i < 3; i++)
			r[i] = sub_sat(x[i], y[i]);
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/rtnh_front.sv -----
`default_nettype none
module rtnh_front import rtnh_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     tri_valid,
	output logic          tri_stall,
	input  wire tri_req_t tri_data,
	output logic          head_valid,
	output tri_ent_t      head,
	input  wire logic     pop
);
	tri_ent_t   mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	vec3_t      va, vb, vc;

	assign tri_stall  = (cnt_q == 2'd2);
	assign push       = tri_valid && !tri_stall;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	assign va = {tri_data.corner_a_z, tri_data.corner_a_y, tri_data.corner_a_x};
	assign vb = {tri_data.corner_b_z, tri_data.corner_b_y, tri_data.corner_b_x};
	assign vc = {tri_data.corner_c_z, tri_data.corner_c_y, tri_data.corner_c_x};

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].a    <= va;
			mem_q[wr_ptr_q].b    <= vb;
			mem_q[wr_ptr_q].c    <= vc;
			mem_q[wr_ptr_q].ab   <= vsub(vb, va);
			mem_q[wr_ptr_q].ac   <= vsub(vc, va);
			mem_q[wr_ptr_q].tag  <= tri_data.surface_tag;
			mem_q[wr_ptr_q].last <= tri_data.final_triangle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/rtnh_div.sv -----
`default_nettype none
module rtnh_div import rtnh_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] num,
	input  wire logic [DIV_W-1:0] den,
	output logic                  done,
	output logic [FRAC_W-1:0]     quot
);
	// restoring division, one quotient bit per cycle, num <= den on entry
	logic [DIV_W:0]      rem_q, den_q, r;
	logic [FRAC_W-1:0]   q_q;
	logic [4:0]          cnt_q;
	logic                busy_q, done_q;

	assign r    = (cnt_q == 5'd0) ? rem_q : {rem_q[DIV_W-1:0], 1'b0};
	assign done = done_q;
	assign quot = q_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= {1'b0, den};
			q_q   <= '0;
		end else if (busy_q) begin
			if (r >= den_q) begin
				rem_q <= r - den_q;
				q_q   <= {q_q[FRAC_W-2:0], 1'b1};
			end else begin
				rem_q <= r;
				q_q   <= {q_q[FRAC_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(FRAC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/rtnh_back.sv -----
`default_nettype none
module rtnh_back import rtnh_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire vec3_t    ray_s,
	input  wire vec3_t    ray_e,
	input  wire logic     head_valid,
	input  wire tri_ent_t head,
	output logic          pop,
	output logic          hit_valid,
	input  wire logic     hit_stall,
	output hit_req_t      hit_data
);
	st_t         state_q, state_d;
	cross_sel_t  csel_q, csel_d;
	dot_sel_t    dsel_q, dsel_d;
	logic [2:0]  k_q, k_d;
	logic        ph_q, ph_d;

	vec3_t       d_q, sa_q, n_q, x_q, p_q, pa_q, pb_q, pc_q;
	logic [FRAC_W-1:0] t_q;
	logic signed [ACC_W-1:0] acc_q, den_q, dsum, cdiff, prod_ext, prod_sh, pt_sum;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;
	vec3_t       cu, cv, du;
	logic [1:0]  j, i1, i2, kk;

	logic        have_q;
	logic [FRAC_W-1:0] bfrac_q;
	logic [7:0]  btag_q;
	vec3_t       bpt_q, bn_q;
	logic        out_valid_q;
	hit_req_t    out_q;

	logic        div_start, div_done, emit;
	logic [FRAC_W-1:0] div_q;
	logic [DIV_W-1:0]  div_num, div_den;
	logic signed [ACC_W-1:0] neg_num, neg_den;

	assign j  = k_q[2:1];
	assign i1 = nxt3(j);
	assign i2 = nxt3(i1);
	assign kk = k_q[1:0];

	always_comb begin
		case (csel_q)
			CS_N:    begin cu = head.ab; cv = head.ac; end
			CS_AB:   begin cu = pa_q;    cv = pb_q;    end
			CS_BC:   begin cu = pb_q;    cv = pc_q;    end
			default: begin cu = pc_q;    cv = pa_q;    end
		endcase
		case (dsel_q)
			DS_DEN:  du = d_q;
			DS_NUM:  du = sa_q;
			default: du = x_q;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_CROSS: begin
				if (k_q[0]) begin
					mul_a = {cu[i2][31], cu[i2]};
					mul_b = {cv[i1][31], cv[i1]};
				end else begin
					mul_a = {cu[i1][31], cu[i1]};
					mul_b = {cv[i2][31], cv[i2]};
				end
			end
			ST_DOT: begin
				mul_a = {du[kk][31], du[kk]};
				mul_b = {n_q[kk][31], n_q[kk]};
			end
			ST_PT: begin
				mul_a = {d_q[kk][31], d_q[kk]};
				mul_b = {16'b0, t_q};
			end
			default: ;
		endcase
	end

	assign prod_ext = ACC_W'(prod_q);
	assign prod_sh  = prod_ext >>> 16;
	assign dsum     = (kk == 2'd0) ? prod_sh : acc_q + prod_sh;
	assign cdiff    = (acc_q - prod_ext) >>> 16;
	assign pt_sum   = ACC_W'($signed(ray_s[kk])) + prod_sh;

	assign neg_num = -acc_q;
	assign neg_den = -den_q;
	assign div_num = neg_num[DIV_W-1:0];
	assign div_den = neg_den[DIV_W-1:0];

	rtnh_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_q)
	);

	assign emit = (state_q == ST_FIN) && head.last && (!out_valid_q || !hit_stall);

	always_comb begin
		state_d   = state_q;
		csel_d    = csel_q;
		dsel_d    = dsel_q;
		k_d       = k_q;
		ph_d      = ph_q;
		pop       = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: if (head_valid) state_d = ST_LOAD;
			ST_LOAD: begin
				state_d = ST_CROSS;
				csel_d  = CS_N;
				k_d     = '0;
				ph_d    = 1'b0;
			end
			ST_CROSS: begin
				ph_d = ~ph_q;
				if (ph_q) begin
					k_d = k_q + 3'd1;
					if (k_q == 3'd5) begin
						state_d = ST_DOT;
						k_d     = '0;
						dsel_d  = (csel_q == CS_N) ? DS_DEN : DS_INS;
					end
				end
			end
			ST_DOT: begin
				ph_d = ~ph_q;
				if (ph_q) begin
					k_d = k_q + 3'd1;
					if (k_q == 3'd2) begin
						k_d = '0;
						unique case (dsel_q)
							DS_DEN: begin
								if (!dsum[ACC_W-1]) state_d = ST_FIN;
								else dsel_d = DS_NUM;
							end
							DS_NUM: begin
								if ((!dsum[ACC_W-1] && dsum != '0) || dsum < den_q)
									state_d = ST_FIN;
								else
									state_d = ST_DIV;
							end
							default: begin
								if (dsum[ACC_W-1]) state_d = ST_FIN;
								else if (csel_q == CS_CA) state_d = ST_UPD;
								else begin
									state_d = ST_CROSS;
									case (csel_q)
										CS_AB:   csel_d = CS_BC;
										default: csel_d = CS_CA;
									endcase
								end
							end
						endcase
					end
				end
			end
			ST_DIV: begin
				// first cycle here launches the divider
				if (!ph_q) begin
					div_start = 1'b1;
					ph_d      = 1'b1;
				end else if (div_done) begin
					ph_d    = 1'b0;
					k_d     = '0;
					state_d = (div_q > bfrac_q) ? ST_FIN : ST_PT;
				end
			end
			ST_PT: begin
				ph_d = ~ph_q;
				if (ph_q) begin
					k_d = k_q + 3'd1;
					if (k_q == 3'd2) begin
						k_d     = '0;
						state_d = ST_DIFF;
					end
				end
			end
			ST_DIFF: begin
				state_d = ST_CROSS;
				csel_d  = CS_AB;
			end
			ST_UPD: state_d = ST_FIN;
			ST_FIN: begin
				if (!head.last || emit) begin
					pop     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			csel_q  <= CS_N;
			dsel_q  <= DS_DEN;
			k_q     <= '0;
			ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			csel_q  <= csel_d;
			dsel_q  <= dsel_d;
			k_q     <= k_d;
			ph_q    <= ph_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (!ph_q)
			prod_q <= mul_a * mul_b;
		case (state_q)
			ST_LOAD: begin
				d_q  <= vsub(ray_e, ray_s);
				sa_q <= vsub(head.a, ray_s);
			end
			ST_CROSS: begin
				if (ph_q) begin
					if (!k_q[0])
						acc_q <= prod_ext;
					else if (csel_q == CS_N)
						n_q[j] <= sat32(cdiff);
					else
						x_q[j] <= sat32(cdiff);
				end
			end
			ST_DOT: begin
				if (ph_q) begin
					acc_q <= dsum;
					if (k_q == 3'd2 && dsel_q == DS_DEN)
						den_q <= dsum;
				end
			end
			ST_DIV: if (div_done) t_q <= div_q;
			ST_PT: if (ph_q) p_q[kk] <= sat32(pt_sum);
			ST_DIFF: begin
				pa_q <= vsub(head.a, p_q);
				pb_q <= vsub(head.b, p_q);
				pc_q <= vsub(head.c, p_q);
			end
			default: ;
		endcase
		if (emit) begin
			out_q.found        <= have_q;
			out_q.hit_tag      <= btag_q;
			out_q.hit_fraction <= bfrac_q;
			out_q.hit_x        <= bpt_q[0];
			out_q.hit_y        <= bpt_q[1];
			out_q.hit_z        <= bpt_q[2];
			out_q.face_nx      <= bn_q[0];
			out_q.face_ny      <= bn_q[1];
			out_q.face_nz      <= bn_q[2];
		end
	end

	// stored best and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			bfrac_q     <= FRAC_ONE;
			btag_q      <= '0;
			bpt_q       <= '0;
			bn_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (hit_valid && !hit_stall)
				out_valid_q <= 1'b0;
			if (state_q == ST_UPD) begin
				have_q  <= 1'b1;
				bfrac_q <= t_q;
				btag_q  <= head.tag;
				bpt_q   <= p_q;
				bn_q    <= n_q;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				have_q      <= 1'b0;
				bfrac_q     <= FRAC_ONE;
				btag_q      <= '0;
				bpt_q       <= '0;
				bn_q        <= '0;
			end
		end
	end

	assign hit_valid = out_valid_q;
	assign hit_data  = out_q;
endmodule
`default_nettype wire

// ----- rtl/core/ray_triangle_nearest_hit.sv -----
// A back facing triangle is dropped early; one that passes every test goes
// through all of them. The result is registered.
// Triangles are worked one at a time, paced by the single shared multiplier
// (42 products) and the divide step (launch, 17 quotient bits, done);
// meanwhile the front can hold the next triangle.
// Reset: arst_n clears control, the stored best and the ray registers.
`default_nettype none
`include "assert_macros.svh"
module ray_triangle_nearest_hit import rtnh_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// triangle requests
	input  wire logic        tri_valid,
	output logic             tri_stall,
	input  wire tri_req_t    tri_data,
	// nearest hit requests
	output logic             hit_valid,
	input  wire logic        hit_stall,
	output hit_req_t         hit_data,
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	// ray segment registers, start in 0..2 and end in 3..5
	vec3_t    ray_s_q, ray_e_q;
	logic     head_valid, pop;
	tri_ent_t head;
	logic     miss_out, miss_clear;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_s_q <= '0;
			ray_e_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SX:  ray_s_q[0] <= cfg_data;
				REG_SY:  ray_s_q[1] <= cfg_data;
				REG_SZ:  ray_s_q[2] <= cfg_data;
				REG_EX:  ray_e_q[0] <= cfg_data;
				REG_EY:  ray_e_q[1] <= cfg_data;
				REG_EZ:  ray_e_q[2] <= cfg_data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	// front: two-deep queue, edges ab and ac formed on entry
	rtnh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tri_valid (tri_valid),
		.tri_stall (tri_stall),
		.tri_data  (tri_data),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	// back: sequencer over one multiplier and the divider; keeps the best hit
	rtnh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ray_s     (ray_s_q),
		.ray_e     (ray_e_q),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.hit_valid (hit_valid),
		.hit_stall (hit_stall),
		.hit_data  (hit_data)
	);

	// a miss reports the cleared best
	assign miss_out   = hit_valid && !hit_data.found;
	assign miss_clear = (hit_data.hit_tag == 8'd0) && (hit_data.face_nx == 32'd0);

	`ASSERT_IMPL(a_miss_frac, clk, arst_n, miss_out, hit_data.hit_fraction == FRAC_ONE)
	`ASSERT_IMPL(a_miss_tag, clk, arst_n, miss_out, miss_clear)
	`ASSERT_IMPL(a_frac_range, clk, arst_n, hit_valid, hit_data.hit_fraction <= FRAC_ONE)
endmodule
`default_nettype wire

// ----- dv/ray_triangle_nearest_hit_tb.sv -----
module ray_triangle_nearest_hit_tb;
	import rtnh_pkg::*;

	typedef struct packed {
		longint x;
		longint y;
		longint z;
	} qvec_t;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam longint UNIT = 64'sd65536;

	logic clk;
	logic arst_n;
	logic tri_valid;
	logic tri_stall;
	tri_req_t tri_data;
	logic hit_valid;
	logic hit_stall;
	hit_req_t hit_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	ray_triangle_nearest_hit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tri_valid(tri_valid),
		.tri_stall(tri_stall),
		.tri_data(tri_data),
		.hit_valid(hit_valid),
		.hit_stall(hit_stall),
		.hit_data(hit_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// triangles waiting to be offered, and nearest hits still owed
	tri_req_t pending_tris[$];
	hit_req_t owed_hits[$];

	// shadow of the ray registers and of the running best
	logic [31:0] ray_regs [NUM_REGS];
	logic best_valid;
	logic [16:0] best_t;
	logic [7:0] best_tag;
	qvec_t best_p;
	qvec_t best_n;

	int send_idle_pct;
	int recv_idle_pct;
	bit send_hold;
	int long_stall_epoch;
	int errors;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ---- fixed point helpers, all worked at 128 bits so nothing wraps ----
	function automatic longint sat_s32(logic signed [127:0] v);
		if (v > S32_MAX)
			return S32_MAX;
		if (v < S32_MIN)
			return S32_MIN;
		return longint'(v);
	endfunction

	function automatic logic signed [127:0] mul_wide(longint x, longint y);
		logic signed [127:0] p;
		logic signed [127:0] q;
		p = x;
		q = y;
		return p * q;
	endfunction

	function automatic longint diff_sat(longint x, longint y);
		logic signed [127:0] p;
		logic signed [127:0] q;
		p = x;
		q = y;
		return sat_s32(p - q);
	endfunction

	function automatic qvec_t vec_diff(qvec_t a, qvec_t b);
		qvec_t r;
		r.x = diff_sat(a.x, b.x);
		r.y = diff_sat(a.y, b.y);
		r.z = diff_sat(a.z, b.z);
		return r;
	endfunction

	function automatic longint cross_term(longint a, longint b, longint c, longint d);
		return sat_s32((mul_wide(a, b) - mul_wide(c, d)) >>> 16);
	endfunction

	function automatic qvec_t vec_cross(qvec_t a, qvec_t b);
		qvec_t r;
		r.x = cross_term(a.y, b.z, a.z, b.y);
		r.y = cross_term(a.z, b.x, a.x, b.z);
		r.z = cross_term(a.x, b.y, a.y, b.x);
		return r;
	endfunction

	function automatic longint vec_dot(qvec_t a, qvec_t b);
		logic signed [127:0] s;
		s = (mul_wide(a.x, b.x) >>> 16) + (mul_wide(a.y, b.y) >>> 16)
			+ (mul_wide(a.z, b.z) >>> 16);
		return longint'(s);
	endfunction

	// restoring division, quotient in Q1.16
	function automatic logic [16:0] frac_quot(longint unsigned num, longint unsigned den);
		longint unsigned rem;
		logic [16:0] q;
		rem = num;
		q = '0;
		if (rem >= den) begin
			rem = rem - den;
			q = 17'd1;
		end
		for (int i = 0; i < 16; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic qvec_t mk_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		qvec_t r;
		r.x = longint'($signed(x));
		r.y = longint'($signed(y));
		r.z = longint'($signed(z));
		return r;
	endfunction

	function automatic qvec_t ray_origin();
		return mk_vec(ray_regs[REG_SX], ray_regs[REG_SY], ray_regs[REG_SZ]);
	endfunction

	function automatic qvec_t ray_dir();
		return vec_diff(mk_vec(ray_regs[REG_EX], ray_regs[REG_EY], ray_regs[REG_EZ]),
			ray_origin());
	endfunction

	function automatic qvec_t tri_normal(tri_req_t r);
		qvec_t a;
		a = mk_vec(r.corner_a_x, r.corner_a_y, r.corner_a_z);
		return vec_cross(vec_diff(mk_vec(r.corner_b_x, r.corner_b_y, r.corner_b_z), a),
			vec_diff(mk_vec(r.corner_c_x, r.corner_c_y, r.corner_c_z), a));
	endfunction

	task automatic clear_best();
		best_valid = 1'b0;
		best_t = FRAC_ONE;
		best_tag = '0;
		best_p = '0;
		best_n = '0;
	endtask

	// one triangle against the ray; a final one also yields the nearest hit
	task automatic trace_triangle(tri_req_t r);
		qvec_t s, d, a, b, c, n, p, pa, pb, pc;
		longint den, num;
		logic [16:0] t;
		bit hit;
		hit_req_t res;
		s = ray_origin();
		d = ray_dir();
		a = mk_vec(r.corner_a_x, r.corner_a_y, r.corner_a_z);
		b = mk_vec(r.corner_b_x, r.corner_b_y, r.corner_b_z);
		c = mk_vec(r.corner_c_x, r.corner_c_y, r.corner_c_z);
		n = tri_normal(r);
		hit = 1'b0;
		den = vec_dot(d, n);
		if (den < 0) begin
			num = vec_dot(vec_diff(a, s), n);
			if (num <= 0 && num >= den) begin
				t = frac_quot(longint'(-num), longint'(-den));
				if (t <= best_t) begin
					p.x = sat_s32(s.x + (mul_wide(d.x, longint'(t)) >>> 16));
					p.y = sat_s32(s.y + (mul_wide(d.y, longint'(t)) >>> 16));
					p.z = sat_s32(s.z + (mul_wide(d.z, longint'(t)) >>> 16));
					pa = vec_diff(a, p);
					pb = vec_diff(b, p);
					pc = vec_diff(c, p);
					hit = vec_dot(vec_cross(pa, pb), n) >= 0
						&& vec_dot(vec_cross(pb, pc), n) >= 0
						&& vec_dot(vec_cross(pc, pa), n) >= 0;
				end
			end
		end
		// a tie in t still replaces: later triangle wins
		if (hit) begin
			best_valid = 1'b1;
			best_t = t;
			best_tag = r.surface_tag;
			best_p = p;
			best_n = n;
		end
		if (r.final_triangle) begin
			res.found = best_valid;
			res.hit_tag = best_tag;
			res.hit_fraction = best_t;
			res.hit_x = best_p.x[31:0];
			res.hit_y = best_p.y[31:0];
			res.hit_z = best_p.z[31:0];
			res.face_nx = best_n.x[31:0];
			res.face_ny = best_n.y[31:0];
			res.face_nz = best_n.z[31:0];
			owed_hits.push_back(res);
			clear_best();
		end
	endtask

	// ---- driver: offers queued triangles, predicts each accepted one ----
	always @(posedge clk) begin
		if (!arst_n) begin
			tri_valid <= 1'b0;
		end else begin
			if (tri_valid && !tri_stall)
				trace_triangle(tri_data);
			if (!tri_valid || !tri_stall) begin
				if (pending_tris.size() > 0 && !send_hold
					&& $urandom_range(99) >= send_idle_pct) begin
					tri_data <= pending_tris.pop_front();
					tri_valid <= 1'b1;
				end else begin
					tri_valid <= 1'b0;
				end
			end
		end
	end

	// ---- monitor: checks each accepted hit against the oldest owed one ----
	int stall_left;
	int stall_seen;
	always @(posedge clk) begin
		hit_req_t exp_hit;
		if (!arst_n) begin
			hit_stall <= 1'b0;
			stall_left <= 0;
			stall_seen <= 0;
		end else begin
			if (hit_valid && !hit_stall) begin
				if (owed_hits.size() == 0) begin
					$display("%0t unexpected hit: expected none, actual %p", $time, hit_data);
					errors++;
				end else begin
					exp_hit = owed_hits.pop_front();
					if (hit_data !== exp_hit) begin
						$display("%0t hit mismatch: expected %p, actual %p",
							$time, exp_hit, hit_data);
						errors++;
					end
				end
			end
			// a long hold-off lets the block back up onto its input
			if (stall_seen != long_stall_epoch) begin
				stall_seen <= long_stall_epoch;
				stall_left <= 400;
				hit_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				hit_stall <= 1'b1;
			end else begin
				hit_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// ---- stimulus ----
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_REGS)
			ray_regs[idx] = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_ray(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
		logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
		write_reg(REG_SX, sx);
		write_reg(REG_SY, sy);
		write_reg(REG_SZ, sz);
		write_reg(REG_EX, ex);
		write_reg(REG_EY, ey);
		write_reg(REG_EZ, ez);
		// index past the last register, dropped by the block
		write_reg(3'($urandom_range(NUM_REGS, 7)), $urandom);
	endtask

	function automatic tri_req_t mk_tri(qvec_t a, qvec_t b, qvec_t c, logic [7:0] tag,
		logic last);
		tri_req_t r;
		r.corner_a_x = a.x[31:0];
		r.corner_a_y = a.y[31:0];
		r.corner_a_z = a.z[31:0];
		r.corner_b_x = b.x[31:0];
		r.corner_b_y = b.y[31:0];
		r.corner_b_z = b.z[31:0];
		r.corner_c_x = c.x[31:0];
		r.corner_c_y = c.y[31:0];
		r.corner_c_z = c.z[31:0];
		r.surface_tag = tag;
		r.final_triangle = last;
		return r;
	endfunction

	function automatic qvec_t jitter(qvec_t q, int span);
		qvec_t r;
		r.x = sat_s32(q.x + $signed($urandom_range(2 * span)) - span);
		r.y = sat_s32(q.y + $signed($urandom_range(2 * span)) - span);
		r.z = sat_s32(q.z + $signed($urandom_range(2 * span)) - span);
		return r;
	endfunction

	// triangle around a point of the segment at fraction f, turned to face the ray
	function automatic tri_req_t aimed_tri(logic [16:0] f, int span, logic last);
		qvec_t s, d, q;
		tri_req_t r;
		s = ray_origin();
		d = ray_dir();
		q.x = sat_s32(s.x + (mul_wide(d.x, longint'(f)) >>> 16));
		q.y = sat_s32(s.y + (mul_wide(d.y, longint'(f)) >>> 16));
		q.z = sat_s32(s.z + (mul_wide(d.z, longint'(f)) >>> 16));
		r = mk_tri(jitter(q, span), jitter(q, span), jitter(q, span), 8'($urandom), last);
		if (vec_dot(d, tri_normal(r)) > 0)
			r = mk_tri(mk_vec(r.corner_a_x, r.corner_a_y, r.corner_a_z),
				mk_vec(r.corner_c_x, r.corner_c_y, r.corner_c_z),
				mk_vec(r.corner_b_x, r.corner_b_y, r.corner_b_z), r.surface_tag, last);
		return r;
	endfunction

	function automatic tri_req_t noise_tri(logic last);
		tri_req_t r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, 9'($urandom)};
		r.final_triangle = last;
		return r;
	endfunction

	task automatic drain_all();
		wait (pending_tris.size() == 0);
		@(posedge clk);
		while (tri_valid || owed_hits.size() > 0)
			@(posedge clk);
		// non-final triangles may still be in flight with nothing owed
		repeat (150) @(posedge clk);
	endtask

	task automatic random_batch(int count);
		int pick;
		logic last;
		for (int i = 0; i < count; i++) begin
			last = (i == count - 1) || ($urandom_range(7) == 0);
			pick = $urandom_range(99);
			if (pick < 70)
				pending_tris.push_back(aimed_tri(17'($urandom_range(65536)),
					$urandom_range(1, 8) * 65536, last));
			else if (pick < 85)
				pending_tris.push_back(noise_tri(last));
			else
				pending_tris.push_back(aimed_tri(17'($urandom_range(65536)),
					$urandom_range(1, 2000), last));
		end
	endtask

	tri_req_t twin;
	qvec_t zv;

	initial begin
		errors = 0;
		send_idle_pct = 33;
		recv_idle_pct = 72;
		send_hold = 1'b0;
		long_stall_epoch = 0;
		tri_valid = 1'b0;
		tri_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hit_stall = 1'b0;
		for (int i = 0; i < NUM_REGS; i++)
			ray_regs[i] = '0;
		clear_best();
		zv = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset ray is a point: nothing can be hit, report stays cleared
		pending_tris.push_back(noise_tri(1'b0));
		pending_tris.push_back(mk_tri(zv, zv, zv, 8'hFF, 1'b1));
		drain_all();

		// ray straight along z, -16.0 to +16.0
		set_ray(32'h0, 32'h0, 32'hFFF0_0000, 32'h0, 32'h0, 32'h0010_0000);
		// extremes of every field
		pending_tris.push_back('1);
		pending_tris.push_back('0);
		pending_tris.push_back(mk_tri(mk_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
			mk_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h0),
			mk_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 8'h00, 1'b1));
		// degenerate: two corners equal, then all three
		pending_tris.push_back(mk_tri(jitter(zv, 65536), zv, zv, 8'h11, 1'b0));
		pending_tris.push_back(mk_tri(zv, zv, zv, 8'h12, 1'b1));
		// front facing hits at the ends of the segment, then a back face at its middle
		pending_tris.push_back(aimed_tri(17'd0, 4 * 65536, 1'b0));
		pending_tris.push_back(aimed_tri(17'd65536, 4 * 65536, 1'b1));
		twin = aimed_tri(17'd32768, 4 * 65536, 1'b0);
		pending_tris.push_back(mk_tri(mk_vec(twin.corner_a_x, twin.corner_a_y, twin.corner_a_z),
			mk_vec(twin.corner_c_x, twin.corner_c_y, twin.corner_c_z),
			mk_vec(twin.corner_b_x, twin.corner_b_y, twin.corner_b_z), 8'h21, 1'b1));
		// equal fraction: the same triangle three times, last tag should win
		twin = mk_tri(mk_vec(32'hFFFB_0000, 32'hFFFB_0000, 32'h0),
			mk_vec(32'h0005_0000, 32'hFFFB_0000, 32'h0),
			mk_vec(32'h0, 32'h0005_0000, 32'h0), 8'h01, 1'b0);
		if (vec_dot(ray_dir(), tri_normal(twin)) > 0)
			twin = mk_tri(mk_vec(twin.corner_a_x, twin.corner_a_y, twin.corner_a_z),
				mk_vec(twin.corner_c_x, twin.corner_c_y, twin.corner_c_z),
				mk_vec(twin.corner_b_x, twin.corner_b_y, twin.corner_b_z), 8'h01, 1'b0);
		pending_tris.push_back(twin);
		twin.surface_tag = 8'hFE;
		pending_tris.push_back(twin);
		twin.surface_tag = 8'h80;
		twin.final_triangle = 1'b1;
		pending_tris.push_back(twin);
		// a miss on its own
		pending_tris.push_back(aimed_tri(17'd40000, 4 * 65536, 1'b0));
		pending_tris.push_back(mk_tri(zv, zv, zv, 8'h55, 1'b1));
		random_batch(90);
		drain_all();

		// diagonal ray with random ends
		set_ray(32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536),
			32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536), 32'hFFE0_0000,
			32'($urandom_range(0, 30 * 65536)), 32'($urandom_range(0, 30 * 65536)),
			32'h0020_0000);
		random_batch(110);
		drain_all();

		// receiver idles less than the sender from here
		send_idle_pct = 72;
		recv_idle_pct = 33;
		// segment across the whole range
		set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		random_batch(100);
		drain_all();

		set_ray(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
		random_batch(60);
		// sender stops until everything owed has come back
		wait (pending_tris.size() == 0);
		send_hold = 1'b1;
		while (tri_valid || owed_hits.size() > 0)
			@(posedge clk);
		send_hold = 1'b0;
		random_batch(50);
		drain_all();

		// no idling on either side, with one long receiver hold-off
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_ray(32'($urandom), 32'($urandom), 32'($urandom),
			32'($urandom), 32'($urandom), 32'($urandom));
		random_batch(60);
		long_stall_epoch++;
		random_batch(60);
		drain_all();

		set_ray(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
			32'hFFFE_0000, 32'h0003_0000, 32'h0000_8000);
		random_batch(60);
		drain_all();

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#40000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ----- ray_triangle_nearest_hit.f -----
+incdir+rtl/core
rtl/core/rtnh_pkg.sv
rtl/core/rtnh_front.sv
rtl/core/rtnh_div.sv
rtl/core/rtnh_back.sv
rtl/core/ray_triangle_nearest_hit.sv
dv/ray_triangle_nearest_hit_tb.sv
